### sv/sfrc_pkg.sv
// Package for the stuffed frame receiver: widths, line codes, status codes,
// the replay beat type and the CRC step function. No dependencies.
`default_nettype none

package sfrc_pkg;

	// Field and storage widths.
	localparam int BYTE_W      = 8;
	localparam int INDEX_W     = 6;
	localparam int STATUS_W    = 2;
	localparam int COUNT_W     = 7;
	localparam int STORE_DEPTH = 64;
	localparam int STORE_AW    = $clog2(STORE_DEPTH);

	// Line codes and CRC polynomial.
	localparam logic [BYTE_W-1:0] ESC_BYTE  = 8'hD7;
	localparam logic [BYTE_W-1:0] SOF_BYTE  = 8'h29;
	localparam logic [BYTE_W-1:0] ZERO_BYTE = 8'h00;
	localparam logic [BYTE_W-1:0] CRC_POLY  = 8'hBC;

	// Frame layout: stored header, address byte, length byte, fixed part.
	localparam int HDR_BYTES    = 3;
	localparam int ADDR_POS     = 3;
	localparam int LEN_POS      = 5;
	localparam int FIXED_BYTES  = 6;
	localparam logic [BYTE_W-1:0] ADDR_RESET = 8'h01;

	typedef enum logic [STATUS_W-1:0] {
		FRAME_OK       = 2'd0,
		FRAME_ADDR_ERR = 2'd1,
		FRAME_CRC_ERR  = 2'd2
	} frame_status_t;

	typedef enum logic {
		ST_IDLE,
		ST_REPLAY
	} rx_state_t;

	// One replayed frame beat.
	typedef struct packed {
		logic [BYTE_W-1:0]  frame_byte;
		logic [INDEX_W-1:0] byte_index;
		frame_status_t      frame_status;
		logic               last_byte;
	} out_beat_t;

	// One table step of the CRC: T(x) = (x >> 1) ^ (x[0] ? poly : 0).
	function automatic logic [BYTE_W-1:0] crc_step(input logic [BYTE_W-1:0] x);
		logic [BYTE_W-1:0] r;
		r = x >> 1;
		if (x[0]) begin
			r = r ^ CRC_POLY;
		end
		return r;
	endfunction

	// Byte of the header that a frame restart puts in front of the store.
	function automatic logic [BYTE_W-1:0] hdr_byte(input logic [1:0] idx);
		logic [BYTE_W-1:0] r;
		unique case (idx)
			2'd1:    r = ESC_BYTE;
			2'd2:    r = SOF_BYTE;
			default: r = ZERO_BYTE;
		endcase
		return r;
	endfunction

	// CRC over the three header bytes, loaded on a restart.
	localparam logic [BYTE_W-1:0] HDR_CRC =
		crc_step(crc_step(crc_step(ZERO_BYTE) ^ ESC_BYTE) ^ SOF_BYTE);

endpackage

`default_nettype wire

### sv/sfrc_if.sv
// Valid/ready channel interfaces of the stuffed frame receiver: the raw
// line byte channel and the replayed frame channel. Depends on sfrc_pkg.
`default_nettype none

interface sfrc_rx_if;
	import sfrc_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfrc_out_if;
	import sfrc_pkg::*;

	logic                valid;
	logic                ready;
	logic [BYTE_W-1:0]   frame_byte;
	logic [INDEX_W-1:0]  byte_index;
	logic [STATUS_W-1:0] frame_status;
	logic                last_byte;

	modport source (output valid, output frame_byte, output byte_index,
		output frame_status, output last_byte, input ready);
	modport sink   (input valid, input frame_byte, input byte_index,
		input frame_status, input last_byte, output ready);
endinterface

`default_nettype wire

### sv/sfrc_out_fifo.sv
// Two-entry output queue for replayed frame beats; reports its fill level
// so the replay reader can keep one read in flight. Depends on sfrc_pkg.
`default_nettype none

module sfrc_out_fifo (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire sfrc_pkg::out_beat_t push_data,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output sfrc_pkg::out_beat_t    out_data,
	output logic [1:0]             occ
);
	import sfrc_pkg::*;

	out_beat_t  entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] occ_q;
	logic       pop;

	assign out_valid = (occ_q != 2'd0);
	assign out_data  = entry_q[rd_ptr_q];
	assign occ       = occ_q;
	assign pop       = out_valid && out_ready;

	// Pointers and fill level; the writer only pushes when there is room.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			occ_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			occ_q <= occ_q + {1'b0, push} - {1'b0, pop};
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

### sv/stuffed_frame_receiver_crc8_core.sv
// Top level of the stuffed frame receiver with 8-bit CRC check.
// Depends on sfrc_pkg, sfrc_rx_if, sfrc_out_if and sfrc_out_fifo.
//
// Usage:
//   rx    : one raw line byte per beat. The stuffing is removed and the
//           unstuffed frame is written into a 64-entry store (single write
//           port, registered read port). A byte that does not end a frame
//           is accepted whenever rx ready is high and causes no output.
//   frame : when the last byte of a frame arrives, the stored frame is
//           replayed, one beat per stored byte, byte_index counting from 0;
//           the final beat has last_byte set and carries the frame status.
//   cfg   : cfg_wr_en/cfg_wr_data write the device address (reset 1).
// Replay: taking the closing byte sets the state register to replay; each
// store read passes the registered read stage into the output queue, which
// offers the beat. The replay runs at one beat per cycle while the frame
// receiver takes beats. rx ready is low while the replay reads the store.
// When the frame receiver stalls, the replay pauses: a two-entry output
// queue absorbs the read in flight and nothing is lost.
// Reset clears the byte count, escape flag, length and CRC; the store itself
// is not cleared, since every entry is written before it is replayed.
`default_nettype none

module stuffed_frame_receiver_crc8_core (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_wr_en,
	input  wire logic [sfrc_pkg::BYTE_W-1:0] cfg_wr_data,
	sfrc_rx_if.sink                          rx,
	sfrc_out_if.source                       frame
);
	import sfrc_pkg::*;

	// Store and control state.
	logic [BYTE_W-1:0]  store_mem [STORE_DEPTH];
	rx_state_t          state_q, state_d;
	logic [COUNT_W-1:0] count_q, count_d;
	logic               esc_q, esc_d;
	logic [BYTE_W-1:0]  len_q, len_d;
	logic [BYTE_W-1:0]  crc_q, crc_d;
	logic               hdr_q, hdr_d;
	logic [BYTE_W-1:0]  addr_byte_q;
	logic [BYTE_W-1:0]  dev_addr_q;
	frame_status_t      status_q, status_d;
	logic [COUNT_W-1:0] n_q;
	logic [COUNT_W-1:0] rd_addr_q;

	// Read stage.
	logic               rd_v_s1;
	logic [BYTE_W-1:0]  mem_rd_s1;
	logic [INDEX_W-1:0] idx_s1;
	logic               hdr_sel_s1;
	logic               last_s1;
	frame_status_t      st_s1;

	// Step decode.
	logic              accept;
	logic [BYTE_W-1:0] b;
	logic              drop, put, restart, end_hit;
	logic [8:0]        end_count;

	// Replay control.
	logic       issue, last_rd;
	logic [1:0] occ;
	logic       pop;
	out_beat_t  push_data, head;

	assign accept = rx.valid && rx.ready;
	assign b      = rx.rx_byte;
	assign rx.ready = (state_q == ST_IDLE);

	// Unstuffing and frame bookkeeping for one accepted byte.
	always_comb begin
		drop    = (count_q >= COUNT_W'(STORE_DEPTH));
		restart = !drop && (b == SOF_BYTE) && esc_q;
		put     = !drop && !restart && !((b == ZERO_BYTE) && esc_q);
		esc_d   = !drop && (b == ESC_BYTE);

		count_d = count_q;
		crc_d   = crc_q;
		hdr_d   = hdr_q;
		len_d   = len_q;
		if (drop) begin
			count_d = '0;
			crc_d   = '0;
		end else if (restart) begin
			count_d = COUNT_W'(HDR_BYTES);
			crc_d   = HDR_CRC;
			hdr_d   = 1'b1;
		end else if (put) begin
			count_d = count_q + COUNT_W'(1);
			crc_d   = crc_step(crc_q ^ b);
			if (count_q < COUNT_W'(HDR_BYTES)) begin
				hdr_d = 1'b0;
			end
			if (count_q == COUNT_W'(LEN_POS)) begin
				len_d = b;
			end
		end

		// The frame closes when the count reaches the fixed part plus length.
		end_count = 9'(FIXED_BYTES) + {1'b0, len_q};
		end_hit   = (count_d > COUNT_W'(FIXED_BYTES))
			&& ({2'b00, count_d} == end_count);

		// Address check first, then the CRC over all bytes but this last one.
		if (addr_byte_q != dev_addr_q) begin
			status_d = FRAME_ADDR_ERR;
		end else if (crc_q == b) begin
			status_d = FRAME_OK;
		end else begin
			status_d = FRAME_CRC_ERR;
		end
	end

	// Replay read issue: keep the queue plus the read in flight within two.
	assign pop     = frame.valid && frame.ready;
	assign issue   = (state_q == ST_REPLAY)
		&& (({1'b0, occ} + {2'b00, rd_v_s1}) < (3'd2 + {2'b00, pop}));
	assign last_rd = (rd_addr_q == (n_q - COUNT_W'(1)));

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && end_hit) begin
					state_d = ST_REPLAY;
				end
			end
			ST_REPLAY: begin
				if (issue && last_rd) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Frame control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			esc_q      <= 1'b0;
			len_q      <= '0;
			crc_q      <= '0;
			hdr_q      <= 1'b0;
			dev_addr_q <= ADDR_RESET;
			rd_addr_q  <= '0;
			n_q        <= '0;
			status_q   <= FRAME_OK;
		end else begin
			if (cfg_wr_en) begin
				dev_addr_q <= cfg_wr_data;
			end
			if (accept) begin
				len_q <= len_d;
				hdr_q <= hdr_d;
				if (end_hit) begin
					count_q   <= '0;
					esc_q     <= 1'b0;
					crc_q     <= '0;
					n_q       <= count_d;
					rd_addr_q <= '0;
					status_q  <= status_d;
				end else begin
					count_q <= count_d;
					esc_q   <= esc_d;
					crc_q   <= crc_d;
				end
			end else if (issue) begin
				rd_addr_q <= rd_addr_q + COUNT_W'(1);
			end
		end
	end

	// Address byte of the current frame, kept for the end-of-frame check.
	always_ff @(posedge clk) begin
		if (accept && put && (count_q == COUNT_W'(ADDR_POS))) begin
			addr_byte_q <= b;
		end
	end

	// Frame store: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (accept && put) begin
			store_mem[count_q[STORE_AW-1:0]] <= b;
		end
		if (issue) begin
			mem_rd_s1 <= store_mem[rd_addr_q[STORE_AW-1:0]];
		end
	end

	// Read stage bookkeeping that travels with the read data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_v_s1 <= 1'b0;
		end else begin
			rd_v_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			idx_s1     <= rd_addr_q[INDEX_W-1:0];
			hdr_sel_s1 <= hdr_q && (rd_addr_q < COUNT_W'(HDR_BYTES));
			last_s1    <= last_rd;
			st_s1      <= last_rd ? status_q : FRAME_OK;
		end
	end

	// Header entries of a restarted frame come from constants.
	always_comb begin
		push_data.frame_byte   = hdr_sel_s1 ? hdr_byte(idx_s1[1:0]) : mem_rd_s1;
		push_data.byte_index   = idx_s1;
		push_data.frame_status = st_s1;
		push_data.last_byte    = last_s1;
	end

	sfrc_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (rd_v_s1),
		.push_data (push_data),
		.out_valid (frame.valid),
		.out_ready (frame.ready),
		.out_data  (head),
		.occ       (occ)
	);

	assign frame.frame_byte   = head.frame_byte;
	assign frame.byte_index   = head.byte_index;
	assign frame.frame_status = STATUS_W'(head.frame_status);
	assign frame.last_byte    = head.last_byte;

endmodule

`default_nettype wire
